@@ hw/rtl/cr_pkg.sv @@
`default_nettype none

package cr_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_BITS  = 24;
    localparam int LINE_BITS    = SAMPLE_BITS + 2;
    localparam int GAIN_BITS    = 17;
    localparam int COEF_BITS    = 20;
    localparam int DELAY_BITS   = 7;
    localparam int ACTIVE_BITS  = 4;
    localparam int FILT_BITS    = 2;
    localparam int CFG_BITS     = 60;
    localparam int CFG_IDX_BITS = 3;
    localparam int OPA_BITS     = 34;
    localparam int OPB_BITS     = 20;
    localparam int ACC_BITS     = 56;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [LINE_BITS-1:0]   line_t;
    typedef logic signed [OPA_BITS-1:0]    opa_t;
    typedef logic signed [OPB_BITS-1:0]    opb_t;
    typedef logic signed [ACC_BITS-1:0]    acc_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WET,
        REG_DRY,
        REG_FEEDBACK,
        REG_DELAY,
        REG_ACTIVE,
        REG_FILTERS,
        REG_LOWPASS,
        REG_HIGHPASS
    } cfg_reg_t;

    // Output scaling constants in Q0.16.
    localparam opb_t SUM_SCALE  = 20'sd6554;
    localparam opb_t DIRECT_MIX = 20'sd39322;
    localparam opb_t CROSS_MIX  = 20'sd26214;

    localparam acc_t LINE_HI   = acc_t'(2 ** (LINE_BITS - 1) - 1);
    localparam acc_t LINE_LO   = acc_t'(-(2 ** (LINE_BITS - 1)));
    localparam acc_t SAMPLE_HI = acc_t'(2 ** (SAMPLE_BITS - 1) - 1);
    localparam acc_t SAMPLE_LO = acc_t'(-(2 ** (SAMPLE_BITS - 1)));

    // Control word of the shared multiply-accumulate unit.
    typedef struct packed {
        logic en;
        logic clear;
        logic rnd;
        logic sub;
        logic load;
    } mac_op_t;

    // Biquad history of one channel.
    typedef struct packed {
        line_t x1;
        line_t x0;
        line_t y1;
        line_t y0;
    } bq_hist_t;

    // Drop 16 fraction bits, rounding to nearest with ties upward.
    function automatic acc_t rnd16(input acc_t v);
        acc_t t;
        t = v + acc_t'(32768);
        return t >>> 16;
    endfunction

    function automatic line_t sat_line(input acc_t v);
        line_t r;
        if (v > LINE_HI)
            r = line_t'(LINE_HI);
        else if (v < LINE_LO)
            r = line_t'(LINE_LO);
        else
            r = line_t'(v);
        return r;
    endfunction

    function automatic sample_t sat_sample(input acc_t v);
        sample_t r;
        if (v > SAMPLE_HI)
            r = sample_t'(SAMPLE_HI);
        else if (v < SAMPLE_LO)
            r = sample_t'(SAMPLE_LO);
        else
            r = sample_t'(v);
        return r;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/comb_reverb_stereo.sv @@
// Channel  Direction  Handshake          Beat contents
// in       input      in_valid/in_stall  sample_in, channel_sel
// out      output     out_valid/out_stall sample_out
// cfg      input      cfg_we             cfg_index, cfg_data
//
// A sample is busy from its acceptance until its result is stored, with steps for
// each of the N active combs and for each filter whose enable bit (L, H) is set;
// the shared multiply-accumulate unit handles at most one product per cycle.
// After reset a clearing pass zeroes the delay memories; no sample is accepted
// until it ends.
// The output register holds a finished sample while out_stall is high.
`default_nettype none

module comb_reverb_stereo #(
    parameter int LINE_DEPTH  = 65536,
    parameter int NUM_COMBS   = 10,
    parameter int CROSS_DELAY = 8000
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [cr_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                   channel_sel,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [cr_pkg::SAMPLE_BITS-1:0] sample_out,
    input  logic                                   cfg_we,
    input  logic [cr_pkg::CFG_IDX_BITS-1:0]        cfg_index,
    input  logic [cr_pkg::CFG_BITS-1:0]            cfg_data
);

    import cr_pkg::*;

    localparam int CD        = 2 * NUM_COMBS * LINE_DEPTH;
    localparam int CAW       = $clog2(CD);
    localparam int XD        = 2 * CROSS_DELAY;
    localparam int XAW       = $clog2(XD);
    localparam int CLEAR_LEN = (CD > XD) ? CD : XD;
    localparam int CLW       = $clog2(CLEAR_LEN);
    localparam int POS_BITS  = $clog2(LINE_DEPTH);
    localparam int SLOTS     = 2 * NUM_COMBS;
    localparam int SW        = $clog2(SLOTS);
    localparam int JW        = (NUM_COMBS > 1) ? $clog2(NUM_COMBS) : 1;
    localparam int CW        = $clog2(NUM_COMBS + 1);
    localparam int XPW       = (CROSS_DELAY > 1) ? $clog2(CROSS_DELAY) : 1;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_ADDR, ST_DRY, ST_TAP, ST_XW,
        ST_BQ0, ST_BQ1, ST_BQ2, ST_BQ3, ST_BQ4, ST_BQY,
        ST_FB, ST_WR, ST_F0, ST_F1, ST_F2, ST_F3
    } state_t;

    // Configuration registers.
    logic [GAIN_BITS-1:0]   wet_gain_reg;
    logic [GAIN_BITS-1:0]   dry_gain_reg;
    logic [GAIN_BITS-1:0]   feedback_gain_reg;
    logic [DELAY_BITS-1:0]  delay_setting_reg;
    logic [ACTIVE_BITS-1:0] active_combs_reg;
    logic [FILT_BITS-1:0]   filter_enables_reg;
    logic [CFG_BITS-1:0]    lowpass_coeffs_reg;
    logic [CFG_BITS-1:0]    highpass_coeffs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wet_gain_reg        <= GAIN_BITS'(32768);
            dry_gain_reg        <= GAIN_BITS'(65536);
            feedback_gain_reg   <= GAIN_BITS'(32768);
            delay_setting_reg   <= DELAY_BITS'(50);
            active_combs_reg    <= ACTIVE_BITS'(1);
            filter_enables_reg  <= '0;
            lowpass_coeffs_reg  <= '0;
            highpass_coeffs_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WET:      wet_gain_reg        <= cfg_data[GAIN_BITS-1:0];
                REG_DRY:      dry_gain_reg        <= cfg_data[GAIN_BITS-1:0];
                REG_FEEDBACK: feedback_gain_reg   <= cfg_data[GAIN_BITS-1:0];
                REG_DELAY:    delay_setting_reg   <= cfg_data[DELAY_BITS-1:0];
                REG_ACTIVE:   active_combs_reg    <= cfg_data[ACTIVE_BITS-1:0];
                REG_FILTERS:  filter_enables_reg  <= cfg_data[FILT_BITS-1:0];
                REG_LOWPASS:  lowpass_coeffs_reg  <= cfg_data;
                REG_HIGHPASS: highpass_coeffs_reg <= cfg_data;
                default:      wet_gain_reg        <= wet_gain_reg;
            endcase
        end
    end

    // Sequencer state and registered outputs.
    state_t             state_reg,   state_next;
    logic [CLW-1:0]     clr_cnt_reg, clr_cnt_next;
    sample_t            x_reg,       x_next;
    logic               ch_reg,      ch_next;
    logic [CW-1:0]      n_reg,       n_next;
    logic [JW-1:0]      j_reg,       j_next;
    logic [CAW-1:0]     at_reg,      at_next;
    logic [POS_BITS-1:0] pos_cur_reg, pos_cur_next;
    opa_t               sum_reg,     sum_next;
    logic               bq_hp_reg,   bq_hp_next;
    line_t              bq_x_reg,    bq_x_next;
    bq_hist_t           lp_hist_reg [2];
    bq_hist_t           lp_hist_next [2];
    bq_hist_t           hp_hist_reg [2];
    bq_hist_t           hp_hist_next [2];
    logic [POS_BITS-1:0] pos_reg [SLOTS];
    logic [POS_BITS-1:0] pos_next [SLOTS];
    logic [XPW-1:0]     cp_reg [2];
    logic [XPW-1:0]     cp_next [2];
    logic               out_valid_reg, out_valid_next;
    sample_t            out_data_reg,  out_data_next;

    // Shared unit and memory connections.
    mac_op_t             mac_op;
    opa_t                mac_a;
    opb_t                mac_b;
    acc_t                mac_load;
    acc_t                acc;
    logic                comb_we;
    logic [CAW-1:0]      comb_waddr;
    logic [LINE_BITS-1:0] comb_wdata;
    logic [LINE_BITS-1:0] comb_rdata;
    logic                cross_we;
    logic [XAW-1:0]      cross_waddr;
    logic [SAMPLE_BITS-1:0] cross_wdata;
    logic [XAW-1:0]      cross_raddr;
    logic [SAMPLE_BITS-1:0] cross_rdata;
    logic [POS_BITS-1:0] limit;

    // Derived values.
    logic [SW-1:0]        slot;
    logic [POS_BITS-1:0]  pos_eff;
    logic [CAW-1:0]       at_comb;
    logic [POS_BITS:0]    pos_inc;
    logic [POS_BITS-1:0]  pos_new;
    logic [CFG_BITS-1:0]  coef;
    opb_t                 b0;
    opb_t                 a1;
    opb_t                 a2;
    bq_hist_t             hist_cur;
    line_t                acc_line;
    line_t                bq_y;
    logic [XPW-1:0]       cp_eff;
    logic [XPW:0]         cp_inc;
    logic [CW-1:0]        n_eff;
    logic                 last_comb;
    logic                 out_free;

    always_comb
    begin
        slot      = SW'(ch_reg) * SW'(NUM_COMBS) + SW'(j_reg);
        pos_eff   = ({1'b0, pos_reg[slot]} >= (POS_BITS + 1)'(LINE_DEPTH)) ? '0 : pos_reg[slot];
        at_comb   = CAW'(slot) * CAW'(LINE_DEPTH) + CAW'(pos_eff);
        pos_inc   = {1'b0, pos_cur_reg} + (POS_BITS + 1)'(1);
        pos_new   = (pos_inc > {1'b0, limit}) ? '0 : pos_inc[POS_BITS-1:0];
        coef      = bq_hp_reg ? highpass_coeffs_reg : lowpass_coeffs_reg;
        b0        = signed'(coef[COEF_BITS-1:0]);
        a1        = signed'(coef[2*COEF_BITS-1:COEF_BITS]);
        a2        = signed'(coef[3*COEF_BITS-1:2*COEF_BITS]);
        hist_cur  = bq_hp_reg ? hp_hist_reg[ch_reg] : lp_hist_reg[ch_reg];
        acc_line  = sat_line(acc);
        bq_y      = sat_line(rnd16(acc));
        cp_eff    = ({1'b0, cp_reg[ch_reg]} >= (XPW + 1)'(CROSS_DELAY)) ? '0 : cp_reg[ch_reg];
        cp_inc    = {1'b0, cp_eff} + (XPW + 1)'(1);
        last_comb = (CW'(j_reg) + CW'(1)) == n_reg;
        out_free  = !out_valid_reg || !out_stall;
        if (active_combs_reg == '0)
            n_eff = CW'(1);
        else if ({1'b0, active_combs_reg} > (ACTIVE_BITS + 1)'(NUM_COMBS))
            n_eff = CW'(NUM_COMBS);
        else
            n_eff = CW'(active_combs_reg);
        cross_raddr = XAW'(!ch_reg) * XAW'(CROSS_DELAY) + XAW'(cp_eff);
    end

    // Sequencer: at most one product per step, and a run of steps for each comb and each enabled filter.
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        x_next         = x_reg;
        ch_next        = ch_reg;
        n_next         = n_reg;
        j_next         = j_reg;
        at_next        = at_reg;
        pos_cur_next   = pos_cur_reg;
        sum_next       = sum_reg;
        bq_hp_next     = bq_hp_reg;
        bq_x_next      = bq_x_reg;
        lp_hist_next   = lp_hist_reg;
        hp_hist_next   = hp_hist_reg;
        pos_next       = pos_reg;
        cp_next        = cp_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        mac_op         = '0;
        mac_a          = '0;
        mac_b          = '0;
        mac_load       = acc_t'(bq_y);
        comb_we        = 1'b0;
        comb_waddr     = at_reg;
        comb_wdata     = acc_line;
        cross_we       = 1'b0;
        cross_waddr    = XAW'(ch_reg) * XAW'(CROSS_DELAY) + XAW'(cp_eff);
        cross_wdata    = sat_sample(acc);

        case (state_reg)
            ST_CLEAR:
            begin
                comb_we     = ({1'b0, clr_cnt_reg} < (CLW + 1)'(CD));
                comb_waddr  = clr_cnt_reg[CAW-1:0];
                comb_wdata  = '0;
                cross_we    = ({1'b0, clr_cnt_reg} < (CLW + 1)'(XD));
                cross_waddr = clr_cnt_reg[XAW-1:0];
                cross_wdata = '0;
                clr_cnt_next = clr_cnt_reg + CLW'(1);
                if ({1'b0, clr_cnt_reg} == (CLW + 1)'(CLEAR_LEN - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next     = sample_in;
                    ch_next    = channel_sel;
                    n_next     = n_eff;
                    j_next     = '0;
                    sum_next   = '0;
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                at_next      = at_comb;
                pos_cur_next = pos_eff;
                state_next   = ST_DRY;
            end
            ST_DRY:
            begin
                mac_op     = '{en: 1'b1, clear: 1'b1, rnd: 1'b1, sub: 1'b0, load: 1'b0};
                mac_a      = opa_t'(x_reg);
                mac_b      = opb_t'({1'b0, dry_gain_reg});
                state_next = ST_TAP;
            end
            ST_TAP:
            begin
                mac_op     = '{en: 1'b1, clear: 1'b0, rnd: 1'b1, sub: 1'b0, load: 1'b0};
                mac_a      = opa_t'(signed'(comb_rdata));
                mac_b      = opb_t'({1'b0, wet_gain_reg});
                state_next = ST_XW;
            end
            ST_XW:
            begin
                // The sum so far is this comb's output; keep it for the final mix.
                sum_next   = sum_reg + signed'(acc[OPA_BITS-1:0]);
                mac_op     = '{en: 1'b1, clear: 1'b0, rnd: 1'b1, sub: 1'b0, load: 1'b0};
                mac_a      = opa_t'(x_reg);
                mac_b      = opb_t'({1'b0, wet_gain_reg});
                bq_hp_next = !filter_enables_reg[0];
                if (filter_enables_reg != '0)
                    state_next = ST_BQ0;
                else
                    state_next = ST_FB;
            end
            ST_BQ0:
            begin
                bq_x_next  = acc_line;
                mac_op     = '{en: 1'b1, clear: 1'b1, rnd: 1'b0, sub: 1'b0, load: 1'b0};
                mac_a      = opa_t'(acc_line);
                mac_b      = b0;
                state_next = ST_BQ1;
            end
            ST_BQ1:
            begin
                // The middle feedforward tap is twice b0, negated for the highpass.
                mac_op     = '{en: 1'b1, clear: 1'b0, rnd: 1'b0, sub: bq_hp_reg, load: 1'b0};
                mac_a      = opa_t'(hist_cur.x1) <<< 1;
                mac_b      = b0;
                state_next = ST_BQ2;
            end
            ST_BQ2:
            begin
                mac_op     = '{en: 1'b1, clear: 1'b0, rnd: 1'b0, sub: 1'b0, load: 1'b0};
                mac_a      = opa_t'(hist_cur.x0);
                mac_b      = b0;
                state_next = ST_BQ3;
            end
            ST_BQ3:
            begin
                mac_op     = '{en: 1'b1, clear: 1'b0, rnd: 1'b0, sub: 1'b1, load: 1'b0};
                mac_a      = opa_t'(hist_cur.y1);
                mac_b      = a1;
                state_next = ST_BQ4;
            end
            ST_BQ4:
            begin
                mac_op     = '{en: 1'b1, clear: 1'b0, rnd: 1'b0, sub: 1'b1, load: 1'b0};
                mac_a      = opa_t'(hist_cur.y0);
                mac_b      = a2;
                state_next = ST_BQY;
            end
            ST_BQY:
            begin
                // Round and clip the filter output, then shift the history.
                mac_op   = '{en: 1'b1, clear: 1'b0, rnd: 1'b0, sub: 1'b0, load: 1'b1};
                mac_load = acc_t'(bq_y);
                if (bq_hp_reg)
                    hp_hist_next[ch_reg] = '{x1: bq_x_reg, x0: hist_cur.x1,
                                             y1: bq_y, y0: hist_cur.y1};
                else
                    lp_hist_next[ch_reg] = '{x1: bq_x_reg, x0: hist_cur.x1,
                                             y1: bq_y, y0: hist_cur.y1};
                if (!bq_hp_reg && filter_enables_reg[1])
                begin
                    bq_hp_next = 1'b1;
                    state_next = ST_BQ0;
                end
                else
                begin
                    state_next = ST_FB;
                end
            end
            ST_FB:
            begin
                mac_op     = '{en: 1'b1, clear: 1'b1, rnd: 1'b1, sub: 1'b0, load: 1'b0};
                mac_a      = opa_t'(acc_line);
                mac_b      = opb_t'({1'b0, feedback_gain_reg});
                state_next = ST_WR;
            end
            ST_WR:
            begin
                comb_we        = 1'b1;
                pos_next[slot] = pos_new;
                if (last_comb)
                begin
                    state_next = ST_F0;
                end
                else
                begin
                    j_next     = j_reg + JW'(1);
                    state_next = ST_ADDR;
                end
            end
            ST_F0:
            begin
                mac_op     = '{en: 1'b1, clear: 1'b1, rnd: 1'b1, sub: 1'b0, load: 1'b0};
                mac_a      = sum_reg;
                mac_b      = SUM_SCALE;
                state_next = ST_F1;
            end
            ST_F1:
            begin
                mac_op     = '{en: 1'b1, clear: 1'b1, rnd: 1'b1, sub: 1'b0, load: 1'b0};
                mac_a      = signed'(acc[OPA_BITS-1:0]);
                mac_b      = DIRECT_MIX;
                state_next = ST_F2;
            end
            ST_F2:
            begin
                mac_op     = '{en: 1'b1, clear: 1'b0, rnd: 1'b1, sub: 1'b0, load: 1'b0};
                mac_a      = opa_t'(signed'(cross_rdata));
                mac_b      = CROSS_MIX;
                state_next = ST_F3;
            end
            ST_F3:
            begin
                // Wait for room in the output register, then store the result.
                if (out_free)
                begin
                    cross_we        = 1'b1;
                    out_valid_next  = 1'b1;
                    out_data_next   = sat_sample(acc);
                    cp_next[ch_reg] = (cp_inc >= (XPW + 1)'(CROSS_DELAY)) ?
                                      '0 : cp_inc[XPW-1:0];
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            x_reg         <= '0;
            ch_reg        <= 1'b0;
            n_reg         <= '0;
            j_reg         <= '0;
            at_reg        <= '0;
            pos_cur_reg   <= '0;
            sum_reg       <= '0;
            bq_hp_reg     <= 1'b0;
            bq_x_reg      <= '0;
            lp_hist_reg   <= '{default: '0};
            hp_hist_reg   <= '{default: '0};
            pos_reg       <= '{default: '0};
            cp_reg        <= '{default: '0};
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            x_reg         <= x_next;
            ch_reg        <= ch_next;
            n_reg         <= n_next;
            j_reg         <= j_next;
            at_reg        <= at_next;
            pos_cur_reg   <= pos_cur_next;
            sum_reg       <= sum_next;
            bq_hp_reg     <= bq_hp_next;
            bq_x_reg      <= bq_x_next;
            lp_hist_reg   <= lp_hist_next;
            hp_hist_reg   <= hp_hist_next;
            pos_reg       <= pos_next;
            cp_reg        <= cp_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // Shared multiply-accumulate unit.
    cr_mac u_mac (
        .clk      (clk),
        .op       (mac_op),
        .a        (mac_a),
        .b        (mac_b),
        .load_val (mac_load),
        .acc      (acc)
    );

    // Line length of the current comb.
    cr_limit #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_limit (
        .clk      (clk),
        .comb_idx (4'(j_reg)),
        .delay    (delay_setting_reg),
        .limit    (limit)
    );

    // Comb delay lines of both channels.
    cr_ram #(
        .DEPTH (CD),
        .WIDTH (LINE_BITS)
    ) u_comb_ram (
        .clk   (clk),
        .we    (comb_we),
        .waddr (comb_waddr),
        .wdata (comb_wdata),
        .raddr (at_reg),
        .rdata (comb_rdata)
    );

    // Cross-channel lines of past outputs.
    cr_ram #(
        .DEPTH (XD),
        .WIDTH (SAMPLE_BITS)
    ) u_cross_ram (
        .clk   (clk),
        .we    (cross_we),
        .waddr (cross_waddr),
        .wdata (cross_wdata),
        .raddr (cross_raddr),
        .rdata (cross_rdata)
    );

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cr_ram.sv @@
`default_nettype none

module cr_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 26
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cr_mac.sv @@
`default_nettype none

module cr_mac (
    input  logic                                clk,
    input  cr_pkg::mac_op_t                     op,
    input  logic signed [cr_pkg::OPA_BITS-1:0] a,
    input  logic signed [cr_pkg::OPB_BITS-1:0] b,
    input  logic signed [cr_pkg::ACC_BITS-1:0] load_val,
    output logic signed [cr_pkg::ACC_BITS-1:0] acc
);

    import cr_pkg::*;

    logic signed [OPA_BITS+OPB_BITS-1:0] prod;
    acc_t term;
    acc_t base;
    acc_t acc_reg;
    acc_t acc_next;

    // A product per enabled cycle, optionally rounded, added or subtracted, or a load.
    always_comb
    begin
        prod = a * b;
        term = op.rnd ? rnd16(acc_t'(prod)) : acc_t'(prod);
        base = op.clear ? '0 : acc_reg;
        acc_next = acc_reg;
        if (op.en)
        begin
            if (op.load)
                acc_next = load_val;
            else if (op.sub)
                acc_next = base - term;
            else
                acc_next = base + term;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cr_limit.sv @@
`default_nettype none

module cr_limit #(
    parameter int LINE_DEPTH = 65536
) (
    input  logic                                   clk,
    input  logic [3:0]                             comb_idx,
    input  logic [cr_pkg::DELAY_BITS-1:0]          delay,
    output logic [$clog2(LINE_DEPTH)-1:0]          limit
);

    import cr_pkg::*;

    localparam int SCALE_BITS = 25;
    localparam int KW       = $clog2(LINE_DEPTH + 1) + SCALE_BITS;
    localparam int PW       = KW + DELAY_BITS + 1;
    localparam int UW       = PW - 24;
    localparam int QW       = UW - 6;
    localparam int POS_BITS = $clog2(LINE_DEPTH);
    localparam longint unsigned RECIP = (64'd1 << UW) / 64'd102;

    // Line shrink factors, round(2^24 / 1.1^j).
    localparam logic [SCALE_BITS-1:0] LEN_SCALE [16] = '{
        25'd16777216, 25'd15252015, 25'd13865468, 25'd12604971,
        25'd11459064, 25'd10417331, 25'd9470301,  25'd8609365,
        25'd7826695,  25'd7115177,  25'd6468343,  25'd5880312,
        25'd5345738,  25'd4859762,  25'd4417965,  25'd4016332
    };

    function automatic logic [KW-1:0] k_of(input logic [3:0] idx);
        return KW'(LINE_DEPTH) * KW'(LEN_SCALE[idx]);
    endfunction

    logic [PW-1:0]       p_reg;
    logic [UW-1:0]       u;
    logic [UW-1:0]       u_reg;
    logic [UW+QW-1:0]    uq;
    logic [QW-1:0]       q0_reg;
    logic [UW-1:0]       rem;
    logic [QW-1:0]       q;
    logic [POS_BITS-1:0] limit_reg;
    logic [DELAY_BITS:0] d1;

    // Divide by 102 through a reciprocal, then fix the quotient by one step.
    always_comb
    begin
        d1  = {1'b0, delay} + (DELAY_BITS + 1)'(1);
        u   = p_reg[PW-1:24];
        uq  = {{QW{1'b0}}, u} * (UW + QW)'(RECIP);
        rem = u_reg - UW'(q0_reg) * UW'(102);
        q   = (rem >= UW'(102)) ? q0_reg + QW'(1) : q0_reg;
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= PW'(d1) * PW'(k_of(comb_idx));
        u_reg  <= u;
        q0_reg <= uq[UW+QW-1:UW];
        if (q > QW'(LINE_DEPTH - 1))
            limit_reg <= POS_BITS'(LINE_DEPTH - 1);
        else
            limit_reg <= POS_BITS'(q);
    end

    assign limit = limit_reg;

endmodule

`default_nettype wire

@@ hw/rtl/cr_checker.sv @@
`default_nettype none

module cr_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_valid,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [cr_pkg::SAMPLE_BITS-1:0] sample_out
);

    // A stalled output beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_out))
        else $error("output beat changed while stalled");

    // An accepted sample makes the block busy, raising in_stall.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall ##1 in_stall)
        else $error("block ready too soon after accepting a sample");

    // A new result appears only at the end of work on a sample.
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared while the block was idle");

    // Finishing a sample returns the block to ready.
    a_ready_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !in_stall)
        else $error("block not ready after delivering a result");

endmodule

bind comb_reverb_stereo cr_checker u_cr_checker (.*);

`default_nettype wire
